@@ rtl/wsd_pkg.sv @@
// Shared constants, status codes and controller command type for the
// work-stealing deque scheduler. Used by wsd_ctrl, wsd_datapath and the top level.
package wsd_pkg;

  localparam int unsigned NUM_QUEUES  = 8;
  localparam int unsigned DEQUE_DEPTH = 1024;

  localparam int unsigned QW    = $clog2(NUM_QUEUES);
  localparam int unsigned NQ_W  = $clog2(NUM_QUEUES + 1);
  localparam int unsigned PW    = $clog2(DEQUE_DEPTH);
  localparam int unsigned SW    = PW + 1;
  localparam int unsigned SLOTS = NUM_QUEUES * DEQUE_DEPTH;
  localparam int unsigned AW    = $clog2(SLOTS);

  localparam int unsigned JOB_W = 64;
  localparam int unsigned QI_W  = 7;
  localparam int unsigned CNT_W = 14;
  localparam int unsigned ST_W  = 3;

  localparam logic [QI_W-1:0] AQ_RESET = QI_W'(1);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_PUSHED = 3'd0,
    ST_FULL   = 3'd1,
    ST_OWN    = 3'd2,
    ST_STOLEN = 3'd3,
    ST_NONE   = 3'd4
  } status_e;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

@@ rtl/wsd_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies; contents are undefined until written.
module wsd_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/wsd_ctrl.sv @@
// Controller state machine of the deque scheduler: accept, execute, report.
// Depends on wsd_pkg for the command type.
module wsd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                done_o,
  output wsd_pkg::ctrl_cmd_t  cmd_o
);
  import wsd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          done_q <= 1'b0;
          if (start) begin
            state_q <= S_EXEC;
            busy_q  <= 1'b1;
          end
        end
        S_EXEC: begin
          state_q <= S_OUT;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        S_OUT: begin
          done_q <= 1'b0;
          if (start) begin
            state_q <= S_EXEC;
            busy_q  <= 1'b1;
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy       = busy_q;
  assign done_o     = done_q;
  assign cmd_o.load = start && !busy_q;
  assign cmd_o.exec = (state_q == S_EXEC);

endmodule

@@ rtl/wsd_datapath.sv @@
// Datapath of the deque scheduler: deque pointers, victim selection, job RAM.
// Depends on wsd_pkg and wsd_ram.
module wsd_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wsd_pkg::ctrl_cmd_t            cmd_i,
  input  logic                          cfg_we_i,
  input  logic [wsd_pkg::QI_W-1:0]      cfg_wdata_i,
  input  logic                          op_i,
  input  logic [wsd_pkg::QI_W-1:0]      queue_index_i,
  input  logic [wsd_pkg::JOB_W-1:0]     job_word_i,
  output logic [wsd_pkg::ST_W-1:0]      status_o,
  output logic [wsd_pkg::JOB_W-1:0]     job_out_o,
  output logic [wsd_pkg::QI_W-1:0]      source_queue_o,
  output logic [wsd_pkg::CNT_W-1:0]     queued_total_o
);
  import wsd_pkg::*;

  logic [QI_W-1:0]  aq_q;
  logic             op_q;
  logic [QI_W-1:0]  qin_q;
  logic [JOB_W-1:0] job_q;

  logic [PW-1:0]    heads_q [NUM_QUEUES];
  logic [PW-1:0]    heads_d [NUM_QUEUES];
  logic [SW-1:0]    sizes_q [NUM_QUEUES];
  logic [SW-1:0]    sizes_d [NUM_QUEUES];
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;

  status_e          status_q;
  logic [QW-1:0]    src_q;
  logic [CNT_W-1:0] total_q;

  logic [NQ_W-1:0]       n_eff;
  logic [QW-1:0]         qc;
  logic [NUM_QUEUES-1:0] hi_vec;
  logic [NUM_QUEUES-1:0] lo_vec;
  logic [QW-1:0]         hi_idx;
  logic [QW-1:0]         lo_idx;
  status_e               kind;
  logic [QW-1:0]         tgt;
  logic [PW-1:0]         head;
  logic [SW-1:0]         size;
  logic [SW-1:0]         pos_sum;
  logic [PW-1:0]         pos;
  logic [AW-1:0]         addr;
  logic                  ram_we;
  logic                  ram_re;
  logic [JOB_W-1:0]      ram_rdata;

  always_comb begin
    if (aq_q == '0) begin
      n_eff = NQ_W'(1);
    end else if (aq_q > QI_W'(NUM_QUEUES)) begin
      n_eff = NQ_W'(NUM_QUEUES);
    end else begin
      n_eff = NQ_W'(aq_q);
    end
    if (qin_q >= QI_W'(n_eff)) begin
      qc = '0;
    end else begin
      qc = QW'(qin_q);
    end
  end

  // Steal order is caller+1 up to the last active queue, then queue 0 upward.
  always_comb begin
    hi_idx = '0;
    lo_idx = '0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      hi_vec[i] = (sizes_q[i] != '0) && (i > int'(qc)) && (i < int'(n_eff));
      lo_vec[i] = (sizes_q[i] != '0) && (i < int'(qc));
    end
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (hi_vec[i]) begin
        hi_idx = QW'(i);
      end
      if (lo_vec[i]) begin
        lo_idx = QW'(i);
      end
    end
  end

  always_comb begin
    tgt = qc;
    if (op_q == OP_PUSH) begin
      kind = (sizes_q[qc] >= SW'(DEQUE_DEPTH)) ? ST_FULL : ST_PUSHED;
    end else if (sizes_q[qc] != '0) begin
      kind = ST_OWN;
    end else if (hi_vec != '0) begin
      kind = ST_STOLEN;
      tgt  = hi_idx;
    end else if (lo_vec != '0) begin
      kind = ST_STOLEN;
      tgt  = lo_idx;
    end else begin
      kind = ST_NONE;
    end
  end

  always_comb begin
    head = heads_q[tgt];
    size = sizes_q[tgt];
    case (kind)
      ST_PUSHED: pos_sum = SW'(head) + size;
      ST_OWN:    pos_sum = SW'(head) + size - SW'(1);
      default:   pos_sum = SW'(head);
    endcase
    if (pos_sum >= SW'(DEQUE_DEPTH)) begin
      pos = PW'(pos_sum - SW'(DEQUE_DEPTH));
    end else begin
      pos = PW'(pos_sum);
    end
    addr   = AW'(tgt) * AW'(DEQUE_DEPTH) + AW'(pos);
    ram_we = cmd_i.exec && (kind == ST_PUSHED);
    ram_re = cmd_i.exec && (kind == ST_OWN || kind == ST_STOLEN);
  end

  always_comb begin
    heads_d = heads_q;
    sizes_d = sizes_q;
    count_d = count_q;
    if (cmd_i.exec) begin
      case (kind)
        ST_PUSHED: begin
          sizes_d[tgt] = size + SW'(1);
          count_d      = count_q + CNT_W'(1);
        end
        ST_OWN: begin
          sizes_d[tgt] = size - SW'(1);
          count_d      = count_q - CNT_W'(1);
        end
        ST_STOLEN: begin
          heads_d[tgt] = (head == PW'(DEQUE_DEPTH - 1)) ? '0 : head + PW'(1);
          sizes_d[tgt] = size - SW'(1);
          count_d      = count_q - CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aq_q    <= AQ_RESET;
      count_q <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        heads_q[i] <= '0;
        sizes_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        aq_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      heads_q <= heads_d;
      sizes_q <= sizes_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      qin_q <= queue_index_i;
      job_q <= job_word_i;
    end
    if (cmd_i.exec) begin
      status_q <= kind;
      src_q    <= (kind == ST_OWN || kind == ST_STOLEN) ? tgt : '0;
      total_q  <= count_d;
    end
  end

  wsd_ram #(
    .Width (JOB_W),
    .Depth (SLOTS)
  ) u_job_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (addr),
    .wdata_i (job_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    case (status_q) inside
      ST_FULL:             job_out_o = job_q;
      ST_OWN, ST_STOLEN:   job_out_o = ram_rdata;
      default:             job_out_o = '0;
    endcase
  end

  assign status_o       = status_q;
  assign source_queue_o = QI_W'(src_q);
  assign queued_total_o = total_q;

endmodule

@@ rtl/work_stealing_deque_scheduler_unit.sv @@
// Top level of the work-stealing deque scheduler.
// Depends on wsd_pkg, wsd_ctrl, wsd_datapath and wsd_ram.
//
// An item is taken when start is high and busy is low. Busy then stays high
// for one cycle, in which the caller's deque or the steal victim is chosen from
// the per-deque non-empty flags and the single-port job RAM is read or written.
// The result appears on the output ports in the next cycle, marked by done_o
// for that one cycle. A new item can be taken while done_o is high, but not
// while busy is high. The result waits on the registered read data of the job
// RAM. Results cannot be held off; the receiver must take each one when done_o
// is high. Write active_queues only while no item is in flight.
module work_stealing_deque_scheduler_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wsd_pkg::QI_W-1:0]      cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op_i,
  input  logic [wsd_pkg::QI_W-1:0]      queue_index_i,
  input  logic [wsd_pkg::JOB_W-1:0]     job_word_i,
  output logic                          done_o,
  output logic [wsd_pkg::ST_W-1:0]      status_o,
  output logic [wsd_pkg::JOB_W-1:0]     job_out_o,
  output logic [wsd_pkg::QI_W-1:0]      source_queue_o,
  output logic [wsd_pkg::CNT_W-1:0]     queued_total_o
);
  import wsd_pkg::*;

  ctrl_cmd_t cmd;

  wsd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  wsd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .op_i           (op_i),
    .queue_index_i  (queue_index_i),
    .job_word_i     (job_word_i),
    .status_o       (status_o),
    .job_out_o      (job_out_o),
    .source_queue_o (source_queue_o),
    .queued_total_o (queued_total_o)
  );

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_exec_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o && !busy)
    else $error("result did not follow the execute cycle");

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without an executed item");

  a_status_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o <= ST_NONE)
    else $error("illegal status code on a result");

endmodule

@@ verif/work_stealing_deque_scheduler_unit_test.sv @@
// Self-checking testbench for work_stealing_deque_scheduler_unit: a directed table, then
// random push/take traffic; results are checked against a shadow copy of the deques or
// against a row's own expected result. Depends on wsd_pkg and the scheduler RTL.
module work_stealing_deque_scheduler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wsd_pkg::*;

  typedef struct {
    status_e          status;
    logic [JOB_W-1:0] job;
    logic [QI_W-1:0]  src;
    logic [CNT_W-1:0] total;
  } result_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic             op;
    logic [QI_W-1:0]  qidx;
    logic [JOB_W-1:0] job;
    bit               typed;
    result_t          res;
  } row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [QI_W-1:0]  cfg_wdata_i;
  logic             start;
  logic             busy;
  logic             op_i;
  logic [QI_W-1:0]  queue_index_i;
  logic [JOB_W-1:0] job_word_i;
  logic             done_o;
  logic [ST_W-1:0]  status_o;
  logic [JOB_W-1:0] job_out_o;
  logic [QI_W-1:0]  source_queue_o;
  logic [CNT_W-1:0] queued_total_o;

  work_stealing_deque_scheduler_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .queue_index_i  (queue_index_i),
    .job_word_i     (job_word_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .job_out_o      (job_out_o),
    .source_queue_o (source_queue_o),
    .queued_total_o (queued_total_o)
  );

  logic [JOB_W-1:0] shadow_slots [NUM_QUEUES][DEQUE_DEPTH];
  int unsigned      shadow_heads [NUM_QUEUES] = '{default: 0};
  int unsigned      shadow_sizes [NUM_QUEUES] = '{default: 0};
  logic [CNT_W-1:0] shadow_total  = '0;
  logic [QI_W-1:0]  shadow_active = AQ_RESET;

  result_t pending_results [$];
  row_t    directed_rows [$];
  int      mismatch_cnt = 0;
  int      idle_pct = 0;
  bit      cur_typed = 0;
  result_t cur_typed_res;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int live_queues();
    int n;
    n = shadow_active;
    if (n == 0) n = 1;
    if (n > NUM_QUEUES) n = NUM_QUEUES;
    return n;
  endfunction

  function automatic result_t predict_dispatch(logic op, logic [QI_W-1:0] qidx,
                                               logic [JOB_W-1:0] job);
    result_t r;
    int n;
    int q;
    int v;
    int i;
    n = live_queues();
    q = qidx;
    if (q >= n) q = 0;
    r.status = ST_NONE;
    r.job    = '0;
    r.src    = '0;
    if (op == OP_PUSH) begin
      if (shadow_sizes[q] >= DEQUE_DEPTH) begin
        r.status = ST_FULL;
        r.job    = job;
      end else begin
        shadow_slots[q][(shadow_heads[q] + shadow_sizes[q]) % DEQUE_DEPTH] = job;
        shadow_sizes[q]++;
        shadow_total++;
        r.status = ST_PUSHED;
      end
    end else begin
      if (shadow_sizes[q] > 0) begin
        shadow_sizes[q]--;
        r.job    = shadow_slots[q][(shadow_heads[q] + shadow_sizes[q]) % DEQUE_DEPTH];
        r.status = ST_OWN;
        r.src    = QI_W'(q);
      end else begin
        for (i = 1; i < n; i++) begin
          v = (q + i) % n;
          if (r.status == ST_NONE && shadow_sizes[v] > 0) begin
            r.job           = shadow_slots[v][shadow_heads[v]];
            shadow_heads[v] = (shadow_heads[v] + 1) % DEQUE_DEPTH;
            shadow_sizes[v]--;
            r.status        = ST_STOLEN;
            r.src           = QI_W'(v);
          end
        end
      end
      if (r.status != ST_NONE) shadow_total--;
    end
    r.total = shadow_total;
    return r;
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    result_t pred;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: status %0d job %h src %0d total %0d",
                     status_o, job_out_o, source_queue_o, queued_total_o);
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status || job_out_o !== want.job ||
              source_queue_o !== want.src || queued_total_o !== want.total) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: status %0d/%0d job %h/%h src %0d/%0d total %0d/%0d",
                       want.status, status_o, want.job, job_out_o,
                       want.src, source_queue_o, want.total, queued_total_o);
          end
        end
      end
      if (cfg_we_i) shadow_active = cfg_wdata_i;
      if (start && !busy) begin
        pred = predict_dispatch(op_i, queue_index_i, job_word_i);
        pending_results.insert(pending_results.size(), cur_typed ? cur_typed_res : pred);
      end
    end
  end

  function automatic void table_row(row_kind_e kind, logic op, logic [QI_W-1:0] qidx,
                                    logic [JOB_W-1:0] job, bit typed = 0,
                                    status_e st = ST_NONE, logic [JOB_W-1:0] jo = '0,
                                    logic [QI_W-1:0] src = '0, logic [CNT_W-1:0] tot = '0);
    row_t r;
    r.kind = kind;
    r.op = op;
    r.qidx = qidx;
    r.job = job;
    r.typed = typed;
    r.res.status = st;
    r.res.job = jo;
    r.res.src = src;
    r.res.total = tot;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with start high.
  task automatic send_item(logic op, logic [QI_W-1:0] qidx, logic [JOB_W-1:0] job,
                           bit typed, result_t res);
    cur_typed     = typed;
    cur_typed_res = res;
    op_i          <= op;
    queue_index_i <= qidx;
    job_word_i    <= job;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
  endtask

  task automatic quiesce();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_active(logic [QI_W-1:0] val);
    quiesce();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_random(int push_pct);
    int n;
    logic op;
    logic [QI_W-1:0] qidx;
    result_t no_res;
    no_res = '{ST_NONE, '0, '0, '0};
    n = live_queues();
    op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_TAKE;
    qidx = ($urandom_range(99) < 85) ? QI_W'($urandom_range(n - 1)) : QI_W'($urandom_range(127));
    send_item(op, qidx, {$urandom, $urandom}, 0, no_res);
    maybe_idle();
  endtask

  initial begin
    int phase_active [12];
    int p;
    int k;
    result_t no_res;
    no_res        = '{ST_NONE, '0, '0, '0};
    phase_active  = '{8, 3, 65, 0, 5, 127, 2, 8, 1, 7, 4, 6};
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    start         <= 1'b0;
    op_i          <= OP_PUSH;
    queue_index_i <= '0;
    job_word_i    <= '0;

    table_row(ROW_ITEM, OP_TAKE, 7'd0, '0, 1, ST_NONE, '0, 7'd0, 14'd0);
    table_row(ROW_ITEM, OP_PUSH, 7'd0, {JOB_W{1'b1}}, 1, ST_PUSHED, '0, 7'd0, 14'd1);
    table_row(ROW_ITEM, OP_PUSH, 7'd127, '0, 1, ST_PUSHED, '0, 7'd0, 14'd2);
    table_row(ROW_ITEM, OP_TAKE, 7'd5, '1, 1, ST_OWN, '0, 7'd0, 14'd1);
    table_row(ROW_ITEM, OP_TAKE, 7'd0, '0, 1, ST_OWN, {JOB_W{1'b1}}, 7'd0, 14'd0);
    table_row(ROW_CFG, OP_PUSH, 7'd8, '0);
    table_row(ROW_ITEM, OP_PUSH, 7'd7, 64'hA5A5_A5A5_5A5A_5A5A);
    table_row(ROW_ITEM, OP_PUSH, 7'd3, 64'h0123_4567_89AB_CDEF);
    table_row(ROW_ITEM, OP_TAKE, 7'd2, '0);
    table_row(ROW_ITEM, OP_TAKE, 7'd6, '0);
    table_row(ROW_ITEM, OP_TAKE, 7'd0, '0, 1, ST_NONE, '0, 7'd0, 14'd0);
    table_row(ROW_ITEM, OP_PUSH, 7'd7, 64'h8000_0000_0000_0001);
    table_row(ROW_CFG, OP_PUSH, 7'd2, '0);
    table_row(ROW_ITEM, OP_TAKE, 7'd1, '0);
    table_row(ROW_CFG, OP_PUSH, 7'd0, '0);
    table_row(ROW_ITEM, OP_TAKE, 7'd127, '0);
    table_row(ROW_CFG, OP_PUSH, 7'd127, '0);
    table_row(ROW_ITEM, OP_TAKE, 7'd0, '0);
    table_row(ROW_CFG, OP_PUSH, 7'd65, '0);
    table_row(ROW_ITEM, OP_PUSH, 7'd64, 64'hDEAD_BEEF_0BAD_F00D);
    table_row(ROW_ITEM, OP_TAKE, 7'd1, '0);
    table_row(ROW_ITEM, OP_PUSH, 7'd4, 64'h1111_2222_3333_4444);
    table_row(ROW_ITEM, OP_PUSH, 7'd4, 64'h5555_6666_7777_8888);
    table_row(ROW_ITEM, OP_TAKE, 7'd3, '0);
    table_row(ROW_ITEM, OP_TAKE, 7'd4, '0);

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_active(directed_rows[i].qidx);
      end else begin
        send_item(directed_rows[i].op, directed_rows[i].qidx, directed_rows[i].job,
                  directed_rows[i].typed, directed_rows[i].res);
      end
    end

    for (p = 0; p < 12; p++) begin
      idle_pct = (p < 4) ? 35 : (p < 8) ? 74 : 0;
      write_active(QI_W'(phase_active[p]));
      for (k = 0; k < 20; k++) begin
        if (p == 5 && k == 10) quiesce();
        send_random((p % 2 == 0) ? 62 : 42);
      end
    end

    // Fill one deque to capacity, then steal from its front so the ring wraps.
    idle_pct = 20;
    write_active(7'd1);
    while (shadow_sizes[0] < DEQUE_DEPTH) begin
      send_item(OP_PUSH, QI_W'($urandom_range(127)), {$urandom, $urandom}, 0, no_res);
      maybe_idle();
    end
    for (k = 0; k < 8; k++) begin
      send_item(OP_PUSH, QI_W'($urandom_range(127)), {$urandom, $urandom}, 0, no_res);
      maybe_idle();
    end
    write_active(7'd2);
    for (k = 0; k < 60; k++) begin
      send_item(OP_TAKE, 7'd1, {$urandom, $urandom}, 0, no_res);
      maybe_idle();
    end
    idle_pct = 0;
    while (shadow_sizes[0] < DEQUE_DEPTH) send_item(OP_PUSH, 7'd0, {$urandom, $urandom}, 0, no_res);
    for (k = 0; k < 40; k++) begin
      send_item((k < 10) ? OP_PUSH : OP_TAKE, QI_W'($urandom_range(1)),
                {$urandom, $urandom}, 0, no_res);
    end

    quiesce();
    repeat (4) @(negedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ work_stealing_deque_scheduler_unit.f @@
rtl/wsd_pkg.sv
rtl/wsd_ram.sv
rtl/wsd_ctrl.sv
rtl/wsd_datapath.sv
rtl/work_stealing_deque_scheduler_unit.sv
verif/work_stealing_deque_scheduler_unit_test.sv
